>>> hw/rtl/sfsg_pkg.sv
// Shared types, constants and helpers for the softsign forward/backward core.
// Used by softsign_forward_backward_core and its testbench; no dependencies.
package sfsg_pkg;

  localparam int unsigned TensorElements = 4096;
  localparam int unsigned IndexWidth     = $clog2(TensorElements);
  localparam int unsigned DataWidth      = 32;
  localparam int unsigned QuoBits        = 17;
  localparam int unsigned RemWidth       = 49;
  localparam int unsigned DvsWidth       = 63;
  localparam int unsigned ProdWidth      = DataWidth + QuoBits;

  // Pipeline register positions.
  localparam int unsigned StRead  = 1;
  localparam int unsigned StMag   = 2;
  localparam int unsigned StSq    = 3;
  localparam int unsigned StDiv0  = 4;
  localparam int unsigned StMul   = StDiv0 + QuoBits + 1;
  localparam int unsigned StOut   = StMul + 1;

  typedef enum logic {
    ACT_FORWARD  = 1'b0,
    ACT_BACKWARD = 1'b1
  } action_t;

  typedef struct packed {
    action_t                act;
    logic                   sign;
    logic [DataWidth-1:0]   gmag;
    logic [RemWidth-1:0]    rem;
    logic [DvsWidth-1:0]    dvs;
    logic [QuoBits-1:0]     quo;
  } div_t;

  function automatic logic [DataWidth-1:0] mag32(input logic [DataWidth-1:0] x);
    mag32 = x[DataWidth-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

>>> hw/rtl/sfsg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sfsg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/softsign_forward_backward_core.sv
// Softsign activation with gradient, signed Q16.16, fully pipelined.
// Depends on sfsg_pkg and sfsg_ram.
//
// Channel   Dir  tdata (low bit up)                      tuser
// s_*       in   element_index[11:0], value[43:12]         action (0 fwd, 1 bwd)
// m_*       out  result_value[31:0]                        -
//
// One item enters per cycle while s_tready is high. The stages are the stored-input RAM
// read, the operand magnitude, the squaring multiplier, the divider setup, a
// 17-stage restoring divider (one quotient bit per stage), the gradient
// multiplier and the output register. Reset clears only the stage valid bits;
// the RAM holds no reset value. A stall at the output first fills empty stages,
// so input transfers continue until every stage holds an item.
module softsign_forward_backward_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // element_index[11:0], value[43:12], zeros above
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // result_value[31:0]
);

  localparam int unsigned DW = sfsg_pkg::DataWidth;
  localparam int unsigned QB = sfsg_pkg::QuoBits;

  logic [sfsg_pkg::StOut:1] vld;
  logic [sfsg_pkg::StOut:1] en;

  // A stage moves when it is empty or its successor moves.
  always_comb begin
    en[sfsg_pkg::StOut] = !vld[sfsg_pkg::StOut] || m_tready;
    for (int k = sfsg_pkg::StOut - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  logic                              acc;
  logic [sfsg_pkg::IndexWidth-1:0]   in_idx;
  logic [DW-1:0]                     in_val;
  sfsg_pkg::action_t                 in_act;

  assign s_tready = en[sfsg_pkg::StRead];
  assign acc      = s_tvalid && s_tready;
  assign in_idx   = s_tdata[sfsg_pkg::IndexWidth-1:0];
  assign in_val   = s_tdata[sfsg_pkg::IndexWidth +: DW];
  assign in_act   = sfsg_pkg::action_t'(s_tuser);

  // Stored forward inputs. A write lands at the transfer edge, so any later
  // backward read of the same entry already sees it.
  logic [DW-1:0] stored;

  sfsg_ram #(
    .Width(DW),
    .Depth(sfsg_pkg::TensorElements)
  ) u_store (
    .clk  (clk),
    .we   (acc && (in_act == sfsg_pkg::ACT_FORWARD)),
    .waddr(in_idx),
    .wdata(in_val),
    .re   (en[sfsg_pkg::StRead]),
    .raddr(in_idx),
    .rdata(stored)
  );

  // Stage 1: side data alongside the RAM read.
  sfsg_pkg::action_t r1_act;
  logic [DW-1:0]     r1_val;

  // Stage 2: operand magnitude and gradient magnitude.
  sfsg_pkg::action_t r2_act;
  logic              r2_sign;
  logic [DW-1:0]     r2_m;
  logic [DW-1:0]     r2_gmag;

  // Stage 3: square of the operand magnitude.
  sfsg_pkg::action_t r3_act;
  logic              r3_sign;
  logic [DW-1:0]     r3_m;
  logic [DW-1:0]     r3_gmag;
  logic [2*DW-1:0]   r3_msq;

  // Divider stages; entry 0 holds the prepared dividend and divisor.
  sfsg_pkg::div_t dv [QB+1];
  sfsg_pkg::div_t dv_next [QB+1];

  // Final stages.
  sfsg_pkg::action_t            r5_act;
  logic                         r5_sign;
  logic [sfsg_pkg::ProdWidth-1:0] r5_prod;
  logic [DW-1:0]                out_data;

  function automatic logic [31:0] out_mag_sel(input sfsg_pkg::action_t a,
                                              input logic [48:0] p);
    out_mag_sel = (a == sfsg_pkg::ACT_FORWARD) ? p[31:0] : p[47:16];
  endfunction

  // Dividend and divisor. Forward: (m << 16) / (1 + m).
  // Backward: 2^48 / (1 + m)^2, with the square built from m*m.
  // Then restoring division, one quotient bit per stage, most significant first.
  always_comb begin
    logic [79:0] dsh;
    dsh = '0;
    dv_next[0] = dv[0];
    dv_next[0].act  = r3_act;
    dv_next[0].sign = r3_sign;
    dv_next[0].gmag = r3_gmag;
    dv_next[0].quo  = '0;
    if (r3_act == sfsg_pkg::ACT_FORWARD) begin
      dv_next[0].rem = sfsg_pkg::RemWidth'({r3_m, 16'h0000});
      dv_next[0].dvs = sfsg_pkg::DvsWidth'({r3_m} + 64'h1_0000);
    end else begin
      dv_next[0].rem = sfsg_pkg::RemWidth'(64'h1_0000_0000_0000);
      dv_next[0].dvs = sfsg_pkg::DvsWidth'(64'h1_0000_0000
                       + ({32'h0, r3_m} << 17) + r3_msq);
    end
    for (int j = 1; j <= QB; j++) begin
      dv_next[j] = dv[j-1];
      dsh = {17'h0, dv[j-1].dvs} << (QB - j);
      if ({31'h0, dv[j-1].rem} >= dsh) begin
        dv_next[j].rem = dv[j-1].rem - dsh[sfsg_pkg::RemWidth-1:0];
        dv_next[j].quo[QB-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[sfsg_pkg::StRead]) begin
        vld[sfsg_pkg::StRead] <= acc;
      end
      for (int k = 2; k <= sfsg_pkg::StOut; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[sfsg_pkg::StRead]) begin
      r1_act <= in_act;
      r1_val <= in_val;
    end
    if (en[sfsg_pkg::StMag]) begin
      r2_act  <= r1_act;
      r2_sign <= r1_val[DW-1];
      r2_gmag <= sfsg_pkg::mag32(r1_val);
      r2_m    <= (r1_act == sfsg_pkg::ACT_FORWARD) ? sfsg_pkg::mag32(r1_val)
                                                   : sfsg_pkg::mag32(stored);
    end
    if (en[sfsg_pkg::StSq]) begin
      r3_act  <= r2_act;
      r3_sign <= r2_sign;
      r3_gmag <= r2_gmag;
      r3_m    <= r2_m;
      r3_msq  <= r2_m * r2_m;
    end
    for (int j = 0; j <= QB; j++) begin
      if (en[sfsg_pkg::StDiv0 + j]) begin
        dv[j] <= dv_next[j];
      end
    end
    if (en[sfsg_pkg::StMul]) begin
      r5_act  <= dv[QB].act;
      r5_sign <= dv[QB].sign;
      r5_prod <= (dv[QB].act == sfsg_pkg::ACT_FORWARD)
                 ? sfsg_pkg::ProdWidth'(dv[QB].quo)
                 : sfsg_pkg::ProdWidth'(dv[QB].gmag) * sfsg_pkg::ProdWidth'(dv[QB].quo);
    end
    if (en[sfsg_pkg::StOut]) begin
      out_data <= r5_sign ? (~out_mag_sel(r5_act, r5_prod) + 1'b1)
                          : out_mag_sel(r5_act, r5_prod);
    end
  end

  assign m_tvalid = vld[sfsg_pkg::StOut];
  assign m_tdata  = out_data;

endmodule

>>> tb/sv/softsign_forward_backward_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for softsign_forward_backward_core.
// Depends on sfsg_pkg for the action codes; drives a directed table and then random traffic.
module softsign_forward_backward_core_tb;
  import sfsg_pkg::*;

  localparam int unsigned QOne      = 65536;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned Latency   = 23;

  typedef struct {
    action_t     act;
    logic [11:0] idx;
    logic [31:0] val;
    logic        has_exp;
    logic [31:0] exp_res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  softsign_forward_backward_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the stored forward inputs, and which entries were written.
  logic [31:0] shadow_inputs [TensorElements];
  bit          written [TensorElements];
  logic [31:0] pending_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned fwd_count = 0;
  int unsigned bwd_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_pct [4][2] = '{'{0, 0}, '{78, 0}, '{0, 78}, '{28, 28}};

  function automatic logic [31:0] abs_q16(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // Forward softsign: sign(x) * floor(|x| * 2^16 / (1 + |x|)).
  function automatic logic [31:0] softsign_out(logic [31:0] x);
    logic [63:0] m;
    logic [63:0] q;
    m = {32'd0, abs_q16(x)};
    q = (m << 16) / (64'(QOne) + m);
    return x[31] ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  // Backward: g * 1/(1+|s|)^2, with the derivative truncated to Q16.16 first.
  function automatic logic [31:0] softsign_grad(logic [31:0] g, logic [31:0] s);
    logic [63:0] den;
    logic [63:0] deriv;
    logic [63:0] prod;
    den   = 64'(QOne) + {32'd0, abs_q16(s)};
    deriv = (64'd1 << 48) / (den * den);
    prod  = ({32'd0, abs_q16(g)} * deriv) >> 16;
    return g[31] ? (32'd0 - prod[31:0]) : prod[31:0];
  endfunction

  // Updates the shadow store and queues the expected result of one transfer.
  task automatic predict_transfer(action_t act, logic [11:0] idx, logic [31:0] val);
    if (act == ACT_FORWARD) begin
      shadow_inputs[idx] = val;
      written[idx] = 1'b1;
      pending_results.push_back(softsign_out(val));
      fwd_count++;
    end else begin
      pending_results.push_back(softsign_grad(val, shadow_inputs[idx]));
      bwd_count++;
    end
  endtask

  // Presents one item and holds it until the transfer happens. The valid
  // stays high afterwards; it drops only on idle cycles or when the caller
  // stops sending.
  task automatic send_item(action_t act, logic [11:0] idx, logic [31:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'd0, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_transfer(act, idx, val);
  endtask

  // Output side: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          logic [31:0] want;
          want = pending_results.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result_value mismatch: expected %h, got %h", want, m_tdata);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("softsign_forward_backward_core_tb: errors");
        $finish;
      end
    end
  end

  // Directed table: extremes of value, both actions, the most negative value,
  // a backward through a zero entry and through the largest stored magnitude.
  row_t directed [20] = '{
    '{ACT_FORWARD,  12'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_FORWARD,  12'd4095, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ACT_FORWARD,  12'd1,    32'h8000_0000, 1'b0, 32'h0},
    '{ACT_FORWARD,  12'd2,    32'h0001_0000, 1'b1, 32'h0000_8000},
    '{ACT_FORWARD,  12'd3,    32'hFFFF_0000, 1'b1, 32'hFFFF_8000},
    '{ACT_FORWARD,  12'd4,    32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ACT_FORWARD,  12'd5,    32'h0000_0001, 1'b1, 32'h0000_0000},
    '{ACT_FORWARD,  12'hAAA,  32'h5555_5555, 1'b0, 32'h0},
    '{ACT_FORWARD,  12'h555,  32'hAAAA_AAAA, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'd0,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ACT_BACKWARD, 12'd0,    32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ACT_BACKWARD, 12'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ACT_BACKWARD, 12'd2,    32'h0001_0000, 1'b1, 32'h0000_4000},
    '{ACT_BACKWARD, 12'd3,    32'hFFFF_0000, 1'b1, 32'hFFFF_C000},
    '{ACT_BACKWARD, 12'd4095, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'd1,    32'h8000_0000, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'd4,    32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'hAAA,  32'h1234_5678, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'h555,  32'hEDCB_A987, 1'b0, 32'h0},
    '{ACT_BACKWARD, 12'd5,    32'h0000_0001, 1'b0, 32'h0}
  };

  // Random value: half small magnitudes up to 4.0, a quarter full range, a quarter near the extremes.
  function automatic logic [31:0] random_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(8 * QOne)) - 4 * QOne);
    endcase
  endfunction

  initial begin
    logic [11:0] idx;
    int unsigned drain;
    for (int i = 0; i < TensorElements; i++) begin
      shadow_inputs[i] = '0;
      written[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      send_item(directed[r].act, directed[r].idx, directed[r].val);
      // A typed-in value is checked against the predictor's entry as well.
      if (directed[r].has_exp && pending_results[$] !== directed[r].exp_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: predictor gives %h, table says %h",
                   r, pending_results[$], directed[r].exp_res);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int n = 0; n < 500; n++) begin
        // Forward on unwritten entries; on written entries, backward two times in three, else forward.
        idx = 12'($urandom_range(TensorElements - 1));
        if (!written[idx] || $urandom_range(2) == 0)
          send_item(ACT_FORWARD, idx, random_value());
        else
          send_item(ACT_BACKWARD, idx, random_value());
      end
      // Hold off the sender until the pipeline has emptied once per phase.
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    recv_stall_pct = 0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (Latency + 5) @(posedge clk);
    $display("covered %0d forward and %0d backward transfers, %0d results checked",
             fwd_count, bwd_count, results_seen);
    $display("idle and stall phases: none, sender 78%%, receiver 78%%, both 28%%");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("softsign_forward_backward_core_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("softsign_forward_backward_core_tb: errors");
    end
    $finish;
  end

endmodule
